// ===== hw/rtl/abtb_pkg.sv =====
package abtb_pkg;

  localparam int GX_W   = 10;
  localparam int GY_W   = 9;
  localparam int ADDR_W = 20;
  localparam int ENV_W  = 10;
  localparam int CALC_W = 12;

  localparam logic signed [CALC_W-1:0] DROOP   = 12'sd8;
  localparam logic signed [CALC_W-1:0] MIN_GAP = 12'sd12;

  localparam logic [7:0] LEVEL_WHITE = 8'd255;
  localparam logic [7:0] LEVEL_BLACK = 8'd0;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_PRINT_WEIGHT = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_RUN,
    ST_SAMP,
    ST_RLOAD,
    ST_RFWD,
    ST_RBWD,
    ST_CLOAD,
    ST_CDOWN,
    ST_CAVG,
    ST_CUP
  } state_t;

  typedef struct packed {
    logic signed [ENV_W-1:0] emax;
    logic signed [ENV_W-1:0] emin;
  } env_pair_t;

  function automatic logic [15:0] sample_pos(input logic [15:0] g, input logic [15:0] d);
    logic [15:0] s;
    s = 16'd4 + {g[12:0], 3'b000};
    if (s >= d) begin
      s = (g != 16'd0) ? s - 16'd8 : d - 16'd1;
    end
    if (s >= d) begin
      s = d - 16'd1;
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/abtb_if.sv =====
interface abtb_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] pixel;
  modport source (output valid, output mode, output pixel, input ready);
  modport sink (input valid, input mode, input pixel, output ready);
endinterface

interface abtb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic       last_pixel;
  modport source (output valid, output level, output last_pixel, input ready);
  modport sink (input valid, input level, input last_pixel, output ready);
endinterface

// ===== hw/rtl/abtb_grid_mem.sv =====
module abtb_grid_mem #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  abtb_pkg::env_pair_t  wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output abtb_pkg::env_pair_t  rdata
);

  abtb_pkg::env_pair_t mem [DEPTH];
  abtb_pkg::env_pair_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/abtb_env_alu.sv =====
module abtb_env_alu (
  input  abtb_pkg::env_pair_t              carry,
  input  abtb_pkg::env_pair_t              entry,
  input  logic [3:0]                       weight,
  output abtb_pkg::env_pair_t              stepped,
  output logic [abtb_pkg::ENV_W-1:0]       avg_max
);

  logic signed [abtb_pkg::CALC_W-1:0] cmax, cmin, emax, emin, xm, xn;
  logic signed [4:0]  wmin, wmax;
  logic signed [15:0] pmin, pmax, tsum;

  always_comb begin
    cmax = abtb_pkg::CALC_W'(carry.emax);
    cmin = abtb_pkg::CALC_W'(carry.emin);
    emax = abtb_pkg::CALC_W'(entry.emax);
    emin = abtb_pkg::CALC_W'(entry.emin);
    xm = cmax - abtb_pkg::DROOP;
    if (cmin + abtb_pkg::DROOP + abtb_pkg::MIN_GAP >= xm) begin
      xn = xm - abtb_pkg::MIN_GAP;
    end else begin
      xn = cmin + abtb_pkg::DROOP;
    end
    stepped.emax = (xm > emax) ? xm[abtb_pkg::ENV_W-1:0] : entry.emax;
    stepped.emin = (xn < emin) ? xn[abtb_pkg::ENV_W-1:0] : entry.emin;
  end

  // threshold from the carried pair, floor by arithmetic shift
  always_comb begin
    wmin = signed'({1'b0, weight});
    wmax = 5'sd8 - wmin;
    pmin = 16'(carry.emin) * 16'(wmin);
    pmax = 16'(carry.emax) * 16'(wmax);
    tsum = pmin + pmax;
    avg_max = tsum[abtb_pkg::ENV_W+2:3];
  end

endmodule

// ===== hw/rtl/adaptive_block_threshold_binarizer.sv =====
// channel   dir  fields              handshake
// in_chan   in   mode, pixel         valid/ready
// out_chan  out  level, last_pixel   valid/ready
// cfg_*     in   index, data         write enable, no wait
//
// Thresholding items: one per cycle in the run state while the output is not stalled;
// grid read at accept, compare as the item enters the output register. Sampling items:
// each grid entry hit (up to four) written in turn. Frame end of sampling pass: envelope
// sweeps, one grid memory port pair, read-modify-write steps; no items taken meanwhile.
// Reset is synchronous; grid memory is not cleared. Output register decouples stalls.
module adaptive_block_threshold_binarizer #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  abtb_in_if.sink          in_chan,
  abtb_out_if.source       out_chan,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [11:0]      cfg_wdata
);

  localparam int GW_MAX = (MAX_WIDTH + 7) / 8;
  localparam int GH_MAX = (MAX_HEIGHT + 7) / 8;
  localparam int DEPTH  = GW_MAX * GH_MAX;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int GXW = abtb_pkg::GX_W;
  localparam int GYW = abtb_pkg::GY_W;
  localparam int ADW = abtb_pkg::ADDR_W;

  logic [11:0] width_r;
  logic [10:0] height_r;
  logic [3:0]  weight_r;
  logic [11:0] col_r, col_nxt;
  logic [10:0] row_r, row_nxt;

  abtb_pkg::state_t state_r, state_nxt;
  logic            ph_r, ph_nxt;
  logic [GXW-1:0]  gx_r, gx_nxt;
  logic [GYW-1:0]  gy_r, gy_nxt;
  logic [ADW-1:0]  yoff_r, yoff_nxt;
  abtb_pkg::env_pair_t carry_r, carry_nxt;

  logic [3:0]     hits_r, hits_nxt;
  logic [GYW-1:0] sgy_r [2];
  logic [GXW-1:0] sgx_r [2];
  logic [7:0]     spix_r;
  logic           slast_r;

  logic       s1_v_r, s1_v_nxt;
  logic [7:0] s1_pix_r;
  logic       s1_last_r;
  logic       out_v_r;
  logic [7:0] out_level_r;
  logic       out_last_r;

  logic [11:0] w_eff;
  logic [10:0] h_eff;
  logic [GXW-1:0] gw;
  logic [GYW-1:0] gh;
  logic last_pos, out_free, s1_move, in_ready, acc;

  logic [GXW-1:0] tgx, cgx [2];
  logic [GYW-1:0] tgy, rgy [2];
  logic [1:0] row_hit, col_hit;
  logic [3:0] hit_mask;
  logic [ADW-1:0] taddr, saddr, gaddr;
  logic [GYW-1:0] sel_gy;
  logic [GXW-1:0] sel_gx;
  logic [3:0] sel_bit;

  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  abtb_pkg::env_pair_t mem_wdata, mem_rdata, stepped;
  logic [abtb_pkg::ENV_W-1:0] avg_max;
  logic [12:0] th;

  always_comb begin
    if (width_r == 12'd0) begin
      w_eff = 12'd1;
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = 12'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == 11'd0) begin
      h_eff = 11'd1;
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_eff = 11'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
    gw = GXW'(({1'b0, w_eff} + 13'd7) >> 3);
    gh = GYW'(({1'b0, h_eff} + 12'd7) >> 3);
    last_pos = (row_r >= h_eff - 11'd1) && (col_r >= w_eff - 12'd1);
  end

  assign out_free = !out_v_r || out_chan.ready;
  assign s1_move  = s1_v_r && out_free;
  assign in_ready = (state_r == abtb_pkg::ST_RUN) && (!s1_v_r || out_free);
  assign acc      = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  always_comb begin
    tgx = {1'b0, col_r[11:3]};
    if (tgx >= gw) begin
      tgx = gw - GXW'(1);
    end
    tgy = {1'b0, row_r[10:3]};
    if (tgy >= gh) begin
      tgy = gh - GYW'(1);
    end
    taddr = ADW'(tgy) * ADW'(gw) + ADW'(tgx);

    rgy[0] = {1'b0, row_r[10:3]};
    rgy[1] = rgy[0] + GYW'(1);
    cgx[0] = {1'b0, col_r[11:3]};
    cgx[1] = cgx[0] + GXW'(1);
    for (int b = 0; b < 2; b++) begin
      row_hit[b] = (rgy[b] < gh) &&
                   (abtb_pkg::sample_pos(16'(rgy[b]), 16'(h_eff)) == 16'(row_r));
      col_hit[b] = (cgx[b] < gw) &&
                   (abtb_pkg::sample_pos(16'(cgx[b]), 16'(w_eff)) == 16'(col_r));
    end
    for (int k = 0; k < 4; k++) begin
      hit_mask[k] = row_hit[k / 2] && col_hit[k % 2];
    end

    sel_bit = hits_r & (~hits_r + 4'd1);
    sel_gy  = (sel_bit[2] || sel_bit[3]) ? sgy_r[1] : sgy_r[0];
    sel_gx  = (sel_bit[1] || sel_bit[3]) ? sgx_r[1] : sgx_r[0];
    saddr   = ADW'(sel_gy) * ADW'(gw) + ADW'(sel_gx);
    gaddr   = yoff_r + ADW'(gx_r);
  end

  abtb_env_alu u_alu (
    .carry   (carry_r),
    .entry   (mem_rdata),
    .weight  (weight_r),
    .stepped (stepped),
    .avg_max (avg_max)
  );

  abtb_grid_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    logic step_done;
    logic is_read;
    state_nxt = state_r;
    ph_nxt    = ph_r;
    gx_nxt    = gx_r;
    gy_nxt    = gy_r;
    yoff_nxt  = yoff_r;
    carry_nxt = carry_r;
    hits_nxt  = hits_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = gaddr[AW-1:0];
    mem_raddr = gaddr[AW-1:0];
    mem_wdata = stepped;
    step_done = 1'b0;
    is_read   = 1'b0;

    case (state_r)
      abtb_pkg::ST_RUN: begin
        if (acc) begin
          if (in_chan.mode) begin
            mem_re    = 1'b1;
            mem_raddr = taddr[AW-1:0];
          end else if (hit_mask != 4'd0) begin
            hits_nxt  = hit_mask;
            state_nxt = abtb_pkg::ST_SAMP;
          end else if (last_pos) begin
            gx_nxt    = '0;
            gy_nxt    = '0;
            yoff_nxt  = '0;
            ph_nxt    = 1'b0;
            state_nxt = abtb_pkg::ST_RLOAD;
          end
        end
      end
      abtb_pkg::ST_SAMP: begin
        mem_we    = 1'b1;
        mem_waddr = saddr[AW-1:0];
        mem_wdata.emax = abtb_pkg::ENV_W'(spix_r);
        mem_wdata.emin = abtb_pkg::ENV_W'(spix_r);
        hits_nxt  = hits_r & ~sel_bit;
        if ((hits_r & ~sel_bit) == 4'd0) begin
          if (slast_r) begin
            gx_nxt    = '0;
            gy_nxt    = '0;
            yoff_nxt  = '0;
            ph_nxt    = 1'b0;
            state_nxt = abtb_pkg::ST_RLOAD;
          end else begin
            state_nxt = abtb_pkg::ST_RUN;
          end
        end
      end
      abtb_pkg::ST_CAVG: begin
        mem_we         = 1'b1;
        mem_wdata.emax = avg_max;
        mem_wdata.emin = carry_r.emin;
        if (gy_r == '0) begin
          if (gx_r == gw - GXW'(1)) begin
            state_nxt = abtb_pkg::ST_RUN;
          end else begin
            gx_nxt    = gx_r + GXW'(1);
            state_nxt = abtb_pkg::ST_CLOAD;
          end
        end else begin
          gy_nxt    = gy_r - GYW'(1);
          yoff_nxt  = yoff_r - ADW'(gw);
          state_nxt = abtb_pkg::ST_CUP;
        end
      end
      abtb_pkg::ST_RLOAD, abtb_pkg::ST_RFWD, abtb_pkg::ST_RBWD,
      abtb_pkg::ST_CLOAD, abtb_pkg::ST_CDOWN, abtb_pkg::ST_CUP: begin
        is_read = 1'b1;
      end
      default: begin
        state_nxt = abtb_pkg::ST_RUN;
      end
    endcase

    if (is_read) begin
      if (!ph_r) begin
        if (!s1_v_r) begin
          mem_re = 1'b1;
          ph_nxt = 1'b1;
        end
      end else begin
        ph_nxt    = 1'b0;
        step_done = 1'b1;
        if (state_r == abtb_pkg::ST_RLOAD || state_r == abtb_pkg::ST_CLOAD) begin
          carry_nxt = mem_rdata;
        end else begin
          mem_we    = 1'b1;
          carry_nxt = stepped;
        end
      end
    end

    if (step_done) begin
      case (state_r)
        abtb_pkg::ST_RLOAD, abtb_pkg::ST_RBWD: begin
          if (state_r == abtb_pkg::ST_RLOAD && gw != GXW'(1)) begin
            gx_nxt    = GXW'(1);
            state_nxt = abtb_pkg::ST_RFWD;
          end else if (state_r == abtb_pkg::ST_RBWD && gx_r != '0) begin
            gx_nxt = gx_r - GXW'(1);
          end else if (gy_r == gh - GYW'(1)) begin
            gx_nxt    = '0;
            gy_nxt    = '0;
            yoff_nxt  = '0;
            state_nxt = abtb_pkg::ST_CLOAD;
          end else begin
            gx_nxt    = '0;
            gy_nxt    = gy_r + GYW'(1);
            yoff_nxt  = yoff_r + ADW'(gw);
            state_nxt = abtb_pkg::ST_RLOAD;
          end
        end
        abtb_pkg::ST_RFWD: begin
          if (gx_r == gw - GXW'(1)) begin
            gx_nxt    = gw - GXW'(2);
            state_nxt = abtb_pkg::ST_RBWD;
          end else begin
            gx_nxt = gx_r + GXW'(1);
          end
        end
        abtb_pkg::ST_CLOAD, abtb_pkg::ST_CDOWN: begin
          if (gy_r == gh - GYW'(1)) begin
            state_nxt = abtb_pkg::ST_CAVG;
          end else begin
            gy_nxt    = gy_r + GYW'(1);
            yoff_nxt  = yoff_r + ADW'(gw);
            state_nxt = abtb_pkg::ST_CDOWN;
          end
        end
        abtb_pkg::ST_CUP: begin
          state_nxt = abtb_pkg::ST_CAVG;
        end
        default: begin
          state_nxt = abtb_pkg::ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= abtb_pkg::ST_RUN;
      ph_r    <= 1'b0;
      hits_r  <= 4'd0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      hits_r  <= hits_nxt;
    end
    gx_r    <= gx_nxt;
    gy_r    <= gy_nxt;
    yoff_r  <= yoff_nxt;
    carry_r <= carry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 11'd480;
      weight_r <= 4'd4;
    end else if (cfg_we) begin
      case (cfg_addr)
        abtb_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        abtb_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_wdata[10:0];
        abtb_pkg::REG_PRINT_WEIGHT: weight_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [12:0] c1;
    logic [11:0] r1;
    c1 = {1'b0, col_r} + 13'd1;
    r1 = {1'b0, row_r};
    if (c1 >= {1'b0, w_eff}) begin
      c1 = 13'd0;
      r1 = r1 + 12'd1;
    end
    if (last_pos) begin
      col_nxt = '0;
      row_nxt = '0;
    end else begin
      col_nxt = c1[11:0];
      row_nxt = r1[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !in_chan.mode) begin
      sgy_r   <= rgy;
      sgx_r   <= cgx;
      spix_r  <= in_chan.pixel;
      slast_r <= last_pos;
    end
  end

  assign s1_v_nxt = (acc && in_chan.mode) ? 1'b1 : (s1_move ? 1'b0 : s1_v_r);
  assign th = {{3{mem_rdata.emax[abtb_pkg::ENV_W-1]}}, mem_rdata.emax};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
    if (acc && in_chan.mode) begin
      s1_pix_r  <= in_chan.pixel;
      s1_last_r <= last_pos;
    end
    if (s1_move) begin
      out_level_r <= ({5'd0, s1_pix_r} > th) ? abtb_pkg::LEVEL_WHITE : abtb_pkg::LEVEL_BLACK;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.level      = out_level_r;
  assign out_chan.last_pixel = out_last_r;

  a_sweep_read_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_re && state_r != abtb_pkg::ST_RUN) |-> !s1_v_r)
    else $error("sweep read while a result waits on grid data");

  a_samp_has_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == abtb_pkg::ST_SAMP) |-> (hits_r != 4'd0))
    else $error("sample write state without pending entry");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_free) |=> s1_v_r)
    else $error("pending result dropped");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_chan.mode) |-> !mem_we)
    else $error("grid write during threshold read");

endmodule
